>>> hw/rtl/sdlu_pkg.sv
// Shared types and panel command codes for the shadow-compare panel updater.
package sdlu_pkg;

  localparam logic [15:0] CMD_SET_COL   = 16'h004E;
  localparam logic [15:0] CMD_SET_ROW   = 16'h004F;
  localparam logic [15:0] CMD_WRITE_RAM = 16'h0022;
  localparam logic [15:0] CMD_MASK      = 16'h00FF;
  localparam logic [7:0]  GROUP_RESET   = 8'd40;

  localparam int COL_W = 8;
  localparam int ROW_W = 9;
  localparam int PIX_W = 16;
  localparam int RUN_W = 8;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] val;
  } sdlu_pix_t;

endpackage

>>> hw/rtl/sdlu_if.sv
// Valid/ready channel interfaces: incoming frame pixels and outgoing panel bus words.
interface sdlu_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_column;
  logic [8:0]  pixel_row;
  logic [15:0] pixel_value;

  modport source (output valid, output pixel_column, output pixel_row, output pixel_value,
                  input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, input pixel_value,
                  output ready);
endinterface

interface sdlu_out_if;
  logic        valid;
  logic        ready;
  logic        bus_is_command;
  logic [15:0] bus_word;
  logic        run_last;

  modport source (output valid, output bus_is_command, output bus_word, output run_last,
                  input ready);
  modport sink   (input valid, input bus_is_command, input bus_word, input run_last,
                  output ready);
endinterface

>>> hw/rtl/sdlu_shadow_mem.sv
// Shadow frame memory: one write port, one registered read port, zeroing sweep after reset.
module sdlu_shadow_mem import sdlu_pkg::*; #(
  parameter int DEPTH  = 76800,
  parameter int ADDR_W = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PIX_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  output logic              clearing
);

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic              clear_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [PIX_W-1:0]  wd;

  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    if (clear_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end
  end

  // sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clear_r;

endmodule

>>> hw/rtl/sdlu_word_emit.sv
// Bus word sequencer: turns one written pixel into its six panel bus words.
module sdlu_word_emit import sdlu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  sdlu_pix_t         load_pix,
  output logic              load_ready,
  sdlu_out_if.source        out_bus
);

  localparam logic [2:0] WD_SET_COL = 3'd0;
  localparam logic [2:0] WD_COL     = 3'd1;
  localparam logic [2:0] WD_SET_ROW = 3'd2;
  localparam logic [2:0] WD_ROW     = 3'd3;
  localparam logic [2:0] WD_WRITE   = 3'd4;
  localparam logic [2:0] WD_PIXEL   = 3'd5;

  logic       busy_r;
  logic [2:0] idx_r;
  sdlu_pix_t  pix_r;
  logic       out_fire;

  assign out_fire   = busy_r && out_bus.ready;
  // take the next pixel while the last word of this one leaves
  assign load_ready = !busy_r || (out_fire && idx_r == WD_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= WD_SET_COL;
    end else if (load_valid && load_ready) begin
      busy_r <= 1'b1;
      idx_r  <= WD_SET_COL;
    end else if (out_fire) begin
      if (idx_r == WD_PIXEL) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      pix_r <= load_pix;
    end
  end

  always_comb begin
    out_bus.bus_is_command = 1'b0;
    out_bus.bus_word       = '0;
    out_bus.run_last       = 1'b0;
    unique case (idx_r)
      WD_SET_COL: begin
        out_bus.bus_is_command = 1'b1;
        out_bus.bus_word       = CMD_SET_COL & CMD_MASK;
      end
      WD_COL: begin
        out_bus.bus_word = {{(16-COL_W){1'b0}}, pix_r.col};
      end
      WD_SET_ROW: begin
        out_bus.bus_is_command = 1'b1;
        out_bus.bus_word       = CMD_SET_ROW & CMD_MASK;
      end
      WD_ROW: begin
        out_bus.bus_word = {{(16-ROW_W){1'b0}}, pix_r.row};
      end
      WD_WRITE: begin
        out_bus.bus_is_command = 1'b1;
        out_bus.bus_word       = CMD_WRITE_RAM & CMD_MASK;
      end
      WD_PIXEL: begin
        out_bus.bus_word = pix_r.val;
        out_bus.run_last = 1'b1;
      end
      default: begin
        out_bus.bus_word = '0;
      end
    endcase
  end

  assign out_bus.valid = busy_r;

endmodule

>>> hw/rtl/shadow_diff_lcd_updater.sv
// Top level of the shadow-compare panel updater.
// Pixels come in raster order; each is checked against a shadow copy of the panel held in one
// FRAME_WIDTH*FRAME_HEIGHT x 16 memory. A changed pixel opens a run of itself plus group_length
// further pixels, capped at the row end; every pixel in a run is stored in the shadow and sent as
// six bus words (0x4E, column, 0x4F, row, 0x22, value). A written pixel occupies the word
// sequencer until its six words are taken, and the sequencer takes the next pixel as the last
// word of the one before leaves; unwritten and out-of-frame pixels do not use the sequencer. The
// shadow read is registered, and a back-to-back hit on the pixel just written is forwarded. After
// reset the memory is zeroed by a sweep over all FRAME_WIDTH*FRAME_HEIGHT entries during which no
// pixel is taken; cfg writes are taken at any time.
module shadow_diff_lcd_updater import sdlu_pkg::*; #(
  parameter int FRAME_WIDTH  = 240,
  parameter int FRAME_HEIGHT = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  sdlu_in_if.sink     in_pix,
  sdlu_out_if.source  out_bus
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIM_W  = $clog2(FRAME_WIDTH);
  localparam int SUM_W  = (LIM_W > COL_W + 1) ? LIM_W : COL_W + 1;

  logic [RUN_W-1:0]  group_r;
  logic [RUN_W-1:0]  run_r;
  logic [RUN_W-1:0]  run_nxt;
  logic              s1_valid_r;
  sdlu_pix_t         s1_pix_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_r;
  logic [PIX_W-1:0]  fwd_val_r;

  logic              clearing;
  logic              in_fire;
  logic              in_frame;
  logic              rd_en;
  logic [ADDR_W-1:0] in_addr;
  logic [PIX_W-1:0]  rd_data;
  logic [PIX_W-1:0]  shadow_val;
  logic              run_active;
  logic              changed;
  logic              s1_write;
  logic              s1_fire;
  logic              emit_ready;
  logic [SUM_W-1:0]  span_sum;
  logic [SUM_W-1:0]  span_end;
  sdlu_pix_t         in_word;

  assign in_word.col = in_pix.pixel_column;
  assign in_word.row = in_pix.pixel_row;
  assign in_word.val = in_pix.pixel_value;

  assign in_frame = (32'(in_pix.pixel_column) < 32'(FRAME_WIDTH)) &&
                    (32'(in_pix.pixel_row) < 32'(FRAME_HEIGHT));
  assign in_addr  = ADDR_W'(in_pix.pixel_row) * ADDR_W'(FRAME_WIDTH) +
                    ADDR_W'(in_pix.pixel_column);

  // decide on the pixel held in stage one
  assign shadow_val = fwd_r ? fwd_val_r : rd_data;
  assign run_active = run_r != '0;
  assign changed    = shadow_val != s1_pix_r.val;
  assign s1_write   = run_active || changed;
  assign s1_fire    = s1_valid_r && (!s1_write || emit_ready);

  assign in_pix.ready = !clearing && (!s1_valid_r || s1_fire);
  assign in_fire      = in_pix.valid && in_pix.ready;
  assign rd_en        = in_fire && in_frame;

  // run end: cap at the last column of the row
  assign span_sum = SUM_W'(s1_pix_r.col) + SUM_W'(group_r);
  assign span_end = (span_sum > SUM_W'(FRAME_WIDTH - 1)) ? SUM_W'(FRAME_WIDTH - 1) : span_sum;

  always_comb begin
    run_nxt = run_r;
    if (s1_fire) begin
      if (run_active) begin
        run_nxt = run_r - RUN_W'(1);
      end else if (changed) begin
        run_nxt = RUN_W'(span_end - SUM_W'(s1_pix_r.col));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r    <= GROUP_RESET;
      run_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        group_r <= cfg_wr_data;
      end
      run_r <= run_nxt;
      if (rd_en) begin
        s1_valid_r <= 1'b1;
        // the write of the departing pixel lands after this read: forward it
        fwd_r      <= s1_fire && s1_write && (in_addr == s1_addr_r);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pix_r  <= in_word;
      s1_addr_r <= in_addr;
      fwd_val_r <= s1_pix_r.val;
    end
  end

  sdlu_shadow_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (s1_fire && s1_write),
    .wr_addr  (s1_addr_r),
    .wr_data  (s1_pix_r.val),
    .clearing (clearing)
  );

  sdlu_word_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r && s1_write),
    .load_pix   (s1_pix_r),
    .load_ready (emit_ready),
    .out_bus    (out_bus)
  );

endmodule

>>> tb/sv/shadow_diff_lcd_updater_test.sv
// Self-checking testbench for the shadow-compare panel updater: table plus random pixel streams.
module shadow_diff_lcd_updater_test;
  import sdlu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = 240;
  localparam int FRAME_H = 320;
  localparam int HOLD_CYCLES = 300;
  // the zeroing sweep after reset is the longest quiet stretch of a good run
  localparam int IDLE_LIMIT = 4 * FRAME_W * FRAME_H;
  localparam int PHASE_ITEMS = 35;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_WORDS} exp_mode_t;
  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    logic [7:0]  col;
    logic [8:0]  row;
    logic [15:0] val;
    exp_mode_t   mode;
  } dir_row_t;

  typedef struct packed {
    logic        is_cmd;
    logic [15:0] word;
    logic        last;
  } bus_word_t;

  // group_length is at its reset value of 40 throughout this table
  localparam dir_row_t DIRECTED [19] = '{
    '{8'd0,   9'd0,   16'h0000, EXP_NONE},   // matches the cleared shadow
    '{8'd239, 9'd319, 16'hFFFF, EXP_WORDS},  // last pixel of frame, run capped to nothing
    '{8'd239, 9'd319, 16'hFFFF, EXP_NONE},
    '{8'd240, 9'd0,   16'h1234, EXP_NONE},   // column off the frame
    '{8'd0,   9'd320, 16'h1234, EXP_NONE},   // row off the frame
    '{8'd255, 9'd511, 16'hFFFF, EXP_NONE},
    '{8'd230, 9'd5,   16'h5555, EXP_WORDS},  // run of nine more, cut at the row end
    '{8'd231, 9'd5,   16'h0000, EXP_WORDS},  // unchanged but inside the run
    '{8'd250, 9'd5,   16'hAAAA, EXP_NONE},   // off-frame pixel leaves the run alone
    '{8'd232, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd17,  9'd300, 16'h0000, EXP_WORDS},  // out of order, still taken by the run
    '{8'd233, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd234, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd235, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd236, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd237, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd238, 9'd5,   16'h0000, EXP_WORDS},
    '{8'd239, 9'd5,   16'h0000, EXP_NONE},   // run spent, pixel unchanged
    '{8'd0,   9'd256, 16'h8001, EXP_PREDICT}
  };

  localparam logic [7:0] GROUP_STEPS [7] = '{8'd0, 8'd255, 8'd1, 8'd239, 8'd7, 8'd40, 8'd128};
  localparam logic [10:0] STALL_PATTERN = 11'b101_1001_1101;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  sdlu_in_if  pix_ch ();
  sdlu_out_if bus_ch ();

  shadow_diff_lcd_updater #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_pix      (pix_ch),
    .out_bus     (bus_ch)
  );

  // own copy of the panel contents and the run counter
  bit [15:0]  panel_shadow [FRAME_W*FRAME_H];
  logic [7:0] run_left = 8'd0;
  logic [7:0] group_len = GROUP_RESET;

  bus_word_t  pending_words [$];
  exp_mode_t  pix_exp = EXP_PREDICT;
  int         errors = 0;
  int         quiet_cycles = 0;
  int         burst_left = 0;
  sink_mode_t sink_mode = SINK_ALWAYS;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         pat_idx = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bit pixel_needs_write(logic [7:0] col, logic [8:0] row, logic [15:0] val);
    int addr;
    int run_end;
    bit wr;
    if (col >= FRAME_W || row >= FRAME_H) return 1'b0;
    addr = int'(row) * FRAME_W + int'(col);
    if (run_left != 8'd0) begin
      run_left = run_left - 8'd1;
      wr = 1'b1;
    end else if (panel_shadow[addr] != val) begin
      run_end = int'(col) + int'(group_len);
      if (run_end > FRAME_W - 1) run_end = FRAME_W - 1;
      run_left = 8'(run_end - int'(col));
      wr = 1'b1;
    end else begin
      wr = 1'b0;
    end
    if (wr) panel_shadow[addr] = val;
    return wr;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_bus_word(bus_word_t got);
    bus_word_t want;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word cmd=%0b word=%h last=%0b",
                                got.is_cmd, got.word, got.last));
    end else begin
      want = pending_words.pop_front();
      if (got.is_cmd != want.is_cmd)
        report_mismatch($sformatf("bus_is_command %0b, want %0b", got.is_cmd, want.is_cmd));
      if (got.word != want.word)
        report_mismatch($sformatf("bus_word %h, want %h", got.word, want.word));
      if (got.last != want.last)
        report_mismatch($sformatf("run_last %0b, want %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    bit wr;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (bus_ch.valid && bus_ch.ready) begin
        moved = 1'b1;
        check_bus_word(bus_word_t'{bus_ch.bus_is_command, bus_ch.bus_word, bus_ch.run_last});
      end
      if (pix_ch.valid && pix_ch.ready) begin
        moved = 1'b1;
        wr = pixel_needs_write(pix_ch.pixel_column, pix_ch.pixel_row, pix_ch.pixel_value);
        // a typed row overrides the predicted decision
        if (pix_exp == EXP_NONE) wr = 1'b0;
        if (pix_exp == EXP_WORDS) wr = 1'b1;
        if (wr) begin
          pending_words.push_back(bus_word_t'{1'b1, CMD_SET_COL & CMD_MASK, 1'b0});
          pending_words.push_back(bus_word_t'{1'b0, {8'd0, pix_ch.pixel_column}, 1'b0});
          pending_words.push_back(bus_word_t'{1'b1, CMD_SET_ROW & CMD_MASK, 1'b0});
          pending_words.push_back(bus_word_t'{1'b0, {7'd0, pix_ch.pixel_row}, 1'b0});
          pending_words.push_back(bus_word_t'{1'b1, CMD_WRITE_RAM & CMD_MASK, 1'b0});
          pending_words.push_back(bus_word_t'{1'b0, pix_ch.pixel_value, 1'b1});
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      bus_ch.ready = 1'b0;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: bus_ch.ready = 1'b1;
        SINK_RANDOM: bus_ch.ready = ($urandom_range(0, 3) != 0);
        default: begin
          bus_ch.ready = STALL_PATTERN[pat_idx];
          pat_idx = (pat_idx + 1) % 11;
        end
      endcase
    end
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // offer one pixel and hold it until taken; returns at the following falling edge
  task automatic send_pixel(logic [7:0] col, logic [8:0] row, logic [15:0] val,
                            exp_mode_t mode, bit no_gaps);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        pix_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_ch.pixel_column = col;
    pix_ch.pixel_row = row;
    pix_ch.pixel_value = val;
    pix_exp = mode;
    pix_ch.valid = 1'b1;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pix_ch.valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // let any unwritten pixel still in flight clear the pipeline
    repeat (8) @(negedge clk);
  endtask

  task automatic write_group(logic [7:0] value);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    group_len = value;
  endtask

  // mostly raster segments whose values match the shadow, with changes and stray pixels
  task automatic send_random(int n_items, bit no_gaps);
    int sent;
    int pick;
    int len;
    logic [7:0]  col;
    logic [8:0]  row;
    logic [15:0] val;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        col = 8'($urandom_range(0, 255));
        row = 9'($urandom_range(0, 511));
        val = 16'($urandom);
        send_pixel(col, row, val, EXP_PREDICT, no_gaps);
        if (col < FRAME_W && row < FRAME_H) sent++;
      end else begin
        row = 9'($urandom_range(0, FRAME_H - 1));
        col = 8'($urandom_range(0, FRAME_W - 1));
        len = $urandom_range(1, 24);
        for (int i = 0; i < len && sent < n_items; i++) begin
          pick = $urandom_range(0, 99);
          val = panel_shadow[int'(row) * FRAME_W + int'(col)];
          if (pick >= 60 && pick < 90) val = 16'($urandom);
          else if (pick >= 90) val = val ^ (16'd1 << $urandom_range(0, 15));
          send_pixel(col, row, val, EXP_PREDICT, no_gaps);
          sent++;
          if (col == FRAME_W - 1) break;
          col++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0] g;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_column = 8'd0;
    pix_ch.pixel_row = 9'd0;
    pix_ch.pixel_value = 16'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    sink_mode = SINK_RANDOM;
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].val, DIRECTED[i].mode, 1'b0);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      g = (p == 6) ? 8'($urandom_range(0, 255)) : GROUP_STEPS[p];
      write_group(g);
      sink_mode = sink_mode_t'(p % 3);
      // hold the bus off with long runs queued so the block backs up
      if (p == 1) hold_req++;
      send_random(PHASE_ITEMS, (p == 1) || (p == 4));
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
